// ===== hw/rtl/tfn_pkg.sv =====
// ----------------------------------------------------------------------------
// tfn_pkg
// Shared types and widths for the triangle face normal pipeline.
// ----------------------------------------------------------------------------
package tfn_pkg;

   localparam int VERTEX_DEPTH = 4096;
   localparam int COORD_BITS   = 24;

   localparam int INDEX_BITS  = 12;
   localparam int POS_BITS    = 24;
   localparam int NORMAL_BITS = 16;

   localparam int ADDR_BITS  = $clog2(VERTEX_DEPTH);
   localparam int EDGE_BITS  = COORD_BITS + 1;
   localparam int PROD_BITS  = 2 * EDGE_BITS;
   localparam int CROSS_BITS = PROD_BITS + 1;
   localparam int MAG_BITS   = 2 * COORD_BITS + 2;
   localparam int HALF_BITS  = MAG_BITS / 2;
   localparam int LEN_BITS   = 2 * MAG_BITS;
   localparam int ROOT_BITS  = MAG_BITS;
   localparam int REM_BITS   = ROOT_BITS + 2;
   // scale factor 32767 = 2^QUOT_BITS - 1
   localparam int QUOT_BITS  = 15;
   localparam int NUM_BITS   = MAG_BITS + QUOT_BITS;

   typedef enum logic {
      CMD_WRITE    = 1'b0,
      CMD_TRIANGLE = 1'b1
   } command_type;

   typedef struct packed {
      command_type                  command;
      logic [INDEX_BITS-1:0]        index_a;
      logic [INDEX_BITS-1:0]        index_b;
      logic [INDEX_BITS-1:0]        index_c;
      logic signed [POS_BITS-1:0]   pos_x;
      logic signed [POS_BITS-1:0]   pos_y;
      logic signed [POS_BITS-1:0]   pos_z;
   } req_type;

   typedef struct packed {
      logic signed [NORMAL_BITS-1:0] normal_x;
      logic signed [NORMAL_BITS-1:0] normal_y;
      logic signed [NORMAL_BITS-1:0] normal_z;
      logic                          zero_length;
   } rsp_type;

   typedef logic signed [COORD_BITS-1:0] coord_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type z;
   } coord_vec_type;

   // cross product as magnitude and sign per component (0 = x, 1 = y, 2 = z)
   typedef struct packed {
      logic [2:0][MAG_BITS-1:0] mag;
      logic [2:0]               neg;
      logic                     zero;
   } norm_type;

endpackage

// ===== hw/rtl/tfn_vertex_store.sv =====
// ----------------------------------------------------------------------------
// tfn_vertex_store
// Vertex position memory, two copies for three reads per cycle while requests are accepted.
// ----------------------------------------------------------------------------
module tfn_vertex_store import tfn_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          advance,
   input  logic          accept,
   input  req_type       req,
   output logic          valid_out,
   output coord_vec_type vert_a,
   output coord_vec_type vert_b,
   output coord_vec_type vert_c
);

   localparam int EXT_BITS = 17;

   function automatic logic [ADDR_BITS-1:0] to_addr(input logic [INDEX_BITS-1:0] idx);
      logic [EXT_BITS-1:0] ext;
      ext = EXT_BITS'(idx);
      return ext[ADDR_BITS-1:0];
   endfunction

   function automatic logic in_range(input logic [INDEX_BITS-1:0] idx);
      return EXT_BITS'(idx) < EXT_BITS'(VERTEX_DEPTH);
   endfunction

   coord_vec_type mem0 [VERTEX_DEPTH];
   coord_vec_type mem1 [VERTEX_DEPTH];

   coord_vec_type wr_data;
   logic          wr_en;
   logic          valid_ff;
   logic          ok_a_ff, ok_b_ff, ok_c_ff;
   coord_vec_type rd_a_ff, rd_b_ff, rd_c_ff;

   assign wr_data.x = COORD_BITS'($unsigned(req.pos_x));
   assign wr_data.y = COORD_BITS'($unsigned(req.pos_y));
   assign wr_data.z = COORD_BITS'($unsigned(req.pos_z));
   assign wr_en     = accept && (req.command == CMD_WRITE) && in_range(req.index_a);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem0[to_addr(req.index_a)] <= wr_data;
      end
      if (accept) begin
         rd_a_ff <= mem0[to_addr(req.index_a)];
         rd_b_ff <= mem0[to_addr(req.index_b)];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem1[to_addr(req.index_a)] <= wr_data;
      end
      if (accept) begin
         rd_c_ff <= mem1[to_addr(req.index_c)];
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         ok_a_ff <= in_range(req.index_a);
         ok_b_ff <= in_range(req.index_b);
         ok_c_ff <= in_range(req.index_c);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= accept && (req.command == CMD_TRIANGLE);
      end
   end

   assign valid_out = valid_ff;
   assign vert_a    = ok_a_ff ? rd_a_ff : '0;
   assign vert_b    = ok_b_ff ? rd_b_ff : '0;
   assign vert_c    = ok_c_ff ? rd_c_ff : '0;

endmodule

// ===== hw/rtl/tfn_cross.sv =====
// ----------------------------------------------------------------------------
// tfn_cross
// Edge vectors, exact cross product, magnitude and sign.
// ----------------------------------------------------------------------------
module tfn_cross import tfn_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          advance,
   input  logic          valid_in,
   input  coord_vec_type vert_a,
   input  coord_vec_type vert_b,
   input  coord_vec_type vert_c,
   output logic          valid_out,
   output norm_type      norm_out
);

   logic [3:0] valid_ff;

   logic signed [EDGE_BITS-1:0]  e1_ff [3];
   logic signed [EDGE_BITS-1:0]  e2_ff [3];
   logic signed [PROD_BITS-1:0]  p_ff  [6];
   logic signed [CROSS_BITS-1:0] n_ff  [3];
   logic signed [CROSS_BITS-1:0] abs_in [3];
   norm_type                     norm_in;
   norm_type                     norm_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[2:0], valid_in};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         e1_ff[0] <= EDGE_BITS'(vert_b.x) - EDGE_BITS'(vert_a.x);
         e1_ff[1] <= EDGE_BITS'(vert_b.y) - EDGE_BITS'(vert_a.y);
         e1_ff[2] <= EDGE_BITS'(vert_b.z) - EDGE_BITS'(vert_a.z);
         e2_ff[0] <= EDGE_BITS'(vert_c.x) - EDGE_BITS'(vert_a.x);
         e2_ff[1] <= EDGE_BITS'(vert_c.y) - EDGE_BITS'(vert_a.y);
         e2_ff[2] <= EDGE_BITS'(vert_c.z) - EDGE_BITS'(vert_a.z);

         p_ff[0] <= e1_ff[1] * e2_ff[2];
         p_ff[1] <= e1_ff[2] * e2_ff[1];
         p_ff[2] <= e1_ff[2] * e2_ff[0];
         p_ff[3] <= e1_ff[0] * e2_ff[2];
         p_ff[4] <= e1_ff[0] * e2_ff[1];
         p_ff[5] <= e1_ff[1] * e2_ff[0];

         for (int i = 0; i < 3; i++) begin
            n_ff[i] <= CROSS_BITS'(p_ff[2*i]) - CROSS_BITS'(p_ff[2*i+1]);
         end

         norm_ff <= norm_in;
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         norm_in.neg[i] = n_ff[i][CROSS_BITS-1];
         abs_in[i]      = norm_in.neg[i] ? -n_ff[i] : n_ff[i];
         norm_in.mag[i] = abs_in[i][MAG_BITS-1:0];
      end
      norm_in.zero = (n_ff[0] == '0) && (n_ff[1] == '0) && (n_ff[2] == '0);
   end

   assign valid_out = valid_ff[3];
   assign norm_out  = norm_ff;

endmodule

// ===== hw/rtl/tfn_length.sv =====
// ----------------------------------------------------------------------------
// tfn_length
// Squared length of the cross product from split partial products.
// ----------------------------------------------------------------------------
module tfn_length import tfn_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic                valid_in,
   input  norm_type            norm_in,
   output logic                valid_out,
   output logic [LEN_BITS-1:0] len_out,
   output norm_type            norm_out
);

   logic [2:0] valid_ff;

   logic [2*HALF_BITS-1:0] hh_ff [3];
   logic [2*HALF_BITS-1:0] hl_ff [3];
   logic [2*HALF_BITS-1:0] ll_ff [3];
   logic [LEN_BITS-1:0]    sq_ff [3];
   logic [LEN_BITS-1:0]    len_ff;
   norm_type               norm1_ff, norm2_ff, norm3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[1:0], valid_in};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < 3; i++) begin
            hh_ff[i] <= norm_in.mag[i][MAG_BITS-1:HALF_BITS]
                      * norm_in.mag[i][MAG_BITS-1:HALF_BITS];
            hl_ff[i] <= norm_in.mag[i][MAG_BITS-1:HALF_BITS]
                      * norm_in.mag[i][HALF_BITS-1:0];
            ll_ff[i] <= norm_in.mag[i][HALF_BITS-1:0] * norm_in.mag[i][HALF_BITS-1:0];
            sq_ff[i] <= (LEN_BITS'(hh_ff[i]) << (2 * HALF_BITS))
                      + (LEN_BITS'(hl_ff[i]) << (HALF_BITS + 1))
                      + LEN_BITS'(ll_ff[i]);
         end
         len_ff   <= sq_ff[0] + sq_ff[1] + sq_ff[2];
         norm1_ff <= norm_in;
         norm2_ff <= norm1_ff;
         norm3_ff <= norm2_ff;
      end
   end

   assign valid_out = valid_ff[2];
   assign len_out   = len_ff;
   assign norm_out  = norm3_ff;

endmodule

// ===== hw/rtl/tfn_sqrt.sv =====
// ----------------------------------------------------------------------------
// tfn_sqrt
// Floor square root, one result bit per pipeline stage.
// ----------------------------------------------------------------------------
module tfn_sqrt import tfn_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic                 valid_in,
   input  logic [LEN_BITS-1:0]  len_in,
   input  norm_type             norm_in,
   output logic                 valid_out,
   output logic [ROOT_BITS-1:0] root_out,
   output norm_type             norm_out
);

   logic                 valid_ff [ROOT_BITS];
   logic [REM_BITS-1:0]  rem_ff   [ROOT_BITS];
   logic [ROOT_BITS-1:0] root_ff  [ROOT_BITS];
   logic [LEN_BITS-1:0]  rad_ff   [ROOT_BITS];
   norm_type             norm_ff  [ROOT_BITS];

   for (genvar s = 0; s < ROOT_BITS; s++) begin : g_step
      logic                 valid_prev;
      logic [REM_BITS-1:0]  rem_prev;
      logic [ROOT_BITS-1:0] root_prev;
      logic [LEN_BITS-1:0]  rad_prev;
      norm_type             norm_prev;
      logic [REM_BITS-1:0]  cur;
      logic [REM_BITS-1:0]  trial;

      if (s == 0) begin : g_first
         assign valid_prev = valid_in;
         assign rem_prev   = '0;
         assign root_prev  = '0;
         assign rad_prev   = len_in;
         assign norm_prev  = norm_in;
      end else begin : g_next
         assign valid_prev = valid_ff[s-1];
         assign rem_prev   = rem_ff[s-1];
         assign root_prev  = root_ff[s-1];
         assign rad_prev   = rad_ff[s-1];
         assign norm_prev  = norm_ff[s-1];
      end

      // bring down the next two radicand bits, try root*4+1
      assign cur   = {rem_prev[REM_BITS-3:0], rad_prev[LEN_BITS-1 -: 2]};
      assign trial = {root_prev, 2'b01};

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (advance) begin
            valid_ff[s] <= valid_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            if (cur >= trial) begin
               rem_ff[s]  <= cur - trial;
               root_ff[s] <= {root_prev[ROOT_BITS-2:0], 1'b1};
            end else begin
               rem_ff[s]  <= cur;
               root_ff[s] <= {root_prev[ROOT_BITS-2:0], 1'b0};
            end
            rad_ff[s]  <= rad_prev << 2;
            norm_ff[s] <= norm_prev;
         end
      end
   end

   assign valid_out = valid_ff[ROOT_BITS-1];
   assign root_out  = root_ff[ROOT_BITS-1];
   assign norm_out  = norm_ff[ROOT_BITS-1];

endmodule

// ===== hw/rtl/tfn_divide.sv =====
// ----------------------------------------------------------------------------
// tfn_divide
// Scale each component by 32767 / root, one quotient bit per stage.
// ----------------------------------------------------------------------------
module tfn_divide import tfn_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic                 valid_in,
   input  logic [ROOT_BITS-1:0] root_in,
   input  norm_type             norm_in,
   output logic                 valid_out,
   output rsp_type              rsp_out
);

   localparam int LAST = QUOT_BITS - 1;

   logic                           prep_valid_ff;
   logic [2:0][NUM_BITS-1:0]       prep_num_ff;
   logic [ROOT_BITS-1:0]           prep_root_ff;
   logic [2:0]                     prep_neg_ff;
   logic                           prep_zero_ff;

   logic                           valid_ff [QUOT_BITS];
   logic [2:0][NUM_BITS-1:0]       rem_ff   [QUOT_BITS];
   logic [2:0][QUOT_BITS-1:0]      quot_ff  [QUOT_BITS];
   logic [ROOT_BITS-1:0]           root_ff  [QUOT_BITS];
   logic [2:0]                     neg_ff   [QUOT_BITS];
   logic                           zero_ff  [QUOT_BITS];

   logic                           out_valid_ff;
   rsp_type                        rsp_ff;
   logic [2:0][NORMAL_BITS-1:0]    norm_res;

   // numerator = magnitude * (2^QUOT_BITS - 1)
   always_ff @(posedge clock) begin
      if (reset) begin
         prep_valid_ff <= 1'b0;
      end else if (advance) begin
         prep_valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < 3; i++) begin
            prep_num_ff[i] <= (NUM_BITS'(norm_in.mag[i]) << QUOT_BITS)
                            - NUM_BITS'(norm_in.mag[i]);
         end
         prep_root_ff <= root_in;
         prep_neg_ff  <= norm_in.neg;
         prep_zero_ff <= norm_in.zero;
      end
   end

   for (genvar s = 0; s < QUOT_BITS; s++) begin : g_step
      localparam int BIT = QUOT_BITS - 1 - s;

      logic                      valid_prev;
      logic [2:0][NUM_BITS-1:0]  rem_prev;
      logic [2:0][QUOT_BITS-1:0] quot_prev;
      logic [ROOT_BITS-1:0]      root_prev;
      logic [2:0]                neg_prev;
      logic                      zero_prev;
      logic [NUM_BITS-1:0]       divisor;
      logic [2:0][NUM_BITS-1:0]  rem_nx;
      logic [2:0][QUOT_BITS-1:0] quot_nx;

      if (s == 0) begin : g_first
         assign valid_prev = prep_valid_ff;
         assign rem_prev   = prep_num_ff;
         assign quot_prev  = '0;
         assign root_prev  = prep_root_ff;
         assign neg_prev   = prep_neg_ff;
         assign zero_prev  = prep_zero_ff;
      end else begin : g_next
         assign valid_prev = valid_ff[s-1];
         assign rem_prev   = rem_ff[s-1];
         assign quot_prev  = quot_ff[s-1];
         assign root_prev  = root_ff[s-1];
         assign neg_prev   = neg_ff[s-1];
         assign zero_prev  = zero_ff[s-1];
      end

      assign divisor = NUM_BITS'(root_prev) << BIT;

      always_comb begin
         for (int i = 0; i < 3; i++) begin
            if (rem_prev[i] >= divisor) begin
               rem_nx[i]  = rem_prev[i] - divisor;
               quot_nx[i] = quot_prev[i] | (QUOT_BITS'(1) << BIT);
            end else begin
               rem_nx[i]  = rem_prev[i];
               quot_nx[i] = quot_prev[i];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (advance) begin
            valid_ff[s] <= valid_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[s]  <= rem_nx;
            quot_ff[s] <= quot_nx;
            root_ff[s] <= root_prev;
            neg_ff[s]  <= neg_prev;
            zero_ff[s] <= zero_prev;
         end
      end
   end

   // apply sign; a zero cross product reports all zeros
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (zero_ff[LAST]) begin
            norm_res[i] = '0;
         end else if (neg_ff[LAST][i]) begin
            norm_res[i] = -NORMAL_BITS'(quot_ff[LAST][i]);
         end else begin
            norm_res[i] = NORMAL_BITS'(quot_ff[LAST][i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= valid_ff[LAST];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff.normal_x    <= norm_res[0];
         rsp_ff.normal_y    <= norm_res[1];
         rsp_ff.normal_z    <= norm_res[2];
         rsp_ff.zero_length <= zero_ff[LAST];
      end
   end

   assign valid_out = out_valid_ff;
   assign rsp_out   = rsp_ff;

endmodule

// ===== hw/rtl/triangle_face_normal.sv =====
// ----------------------------------------------------------------------------
// triangle_face_normal
// Vertex store plus a pipelined unit face normal of a triangle.
// ----------------------------------------------------------------------------
//
//   Channel   Ports                            Direction  Transfers
//   request   req_valid, req_stall, req_data   in         write or triangle
//   response  rsp_valid, rsp_stall, rsp_data   out        one normal/triangle
//
// One item per cycle enters while the pipeline advances; a triangle passes the
// vertex store, cross product, length, the one-bit-per-stage square
// root (2*COORD_BITS + 2 stages) and the 15-stage quotient pipeline.
// Writes go to the store at their transfer and produce no response.
// Reset clears the valid bits only; store contents stay undefined until written.
// A response stall while rsp_valid is high freezes every stage at once; req_stall follows it.
//
module triangle_face_normal import tfn_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic                 advance;
   logic                 accept;

   logic                 st_valid;
   coord_vec_type        vert_a, vert_b, vert_c;
   logic                 cr_valid;
   norm_type             cr_norm;
   logic                 ln_valid;
   logic [LEN_BITS-1:0]  ln_len;
   norm_type             ln_norm;
   logic                 sq_valid;
   logic [ROOT_BITS-1:0] sq_root;
   norm_type             sq_norm;

   // advance the whole pipeline unless a held response is stalled
   assign advance   = !rsp_valid || !rsp_stall;
   assign req_stall = !advance;
   assign accept    = req_valid && advance;

   tfn_vertex_store u_store (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .accept    (accept),
      .req       (req_data),
      .valid_out (st_valid),
      .vert_a    (vert_a),
      .vert_b    (vert_b),
      .vert_c    (vert_c)
   );

   tfn_cross u_cross (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .valid_in  (st_valid),
      .vert_a    (vert_a),
      .vert_b    (vert_b),
      .vert_c    (vert_c),
      .valid_out (cr_valid),
      .norm_out  (cr_norm)
   );

   tfn_length u_length (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .valid_in  (cr_valid),
      .norm_in   (cr_norm),
      .valid_out (ln_valid),
      .len_out   (ln_len),
      .norm_out  (ln_norm)
   );

   tfn_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .valid_in  (ln_valid),
      .len_in    (ln_len),
      .norm_in   (ln_norm),
      .valid_out (sq_valid),
      .root_out  (sq_root),
      .norm_out  (sq_norm)
   );

   // final stage register doubles as the response register
   tfn_divide u_divide (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .valid_in  (sq_valid),
      .root_in   (sq_root),
      .norm_in   (sq_norm),
      .valid_out (rsp_valid),
      .rsp_out   (rsp_data)
   );

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives vertex writes and triangle commands into triangle_face_normal and
// checks every normal against an exact cross product, floor square root and
// truncating Q1.15 scaling, under several sender and receiver idle mixes.
// ----------------------------------------------------------------------------
module tb;
   import tfn_pkg::*;

   // Track the vertex stores, predict each triangle's normal and check the
   // responses in order.
   class normal_scoreboard;
      coord_type x_mem[VERTEX_DEPTH];
      coord_type y_mem[VERTEX_DEPTH];
      coord_type z_mem[VERTEX_DEPTH];
      rsp_type   expected_normals[$];
      int        mismatches = 0;

      task report(string msg);
         $display("MISMATCH at %0t: %s", $time, msg);
         mismatches++;
      endtask

      function rsp_type face_normal(req_type r);
         longint    ax, ay, az, e1x, e1y, e1z, e2x, e2y, e2z;
         longint    n[3];
         logic [127:0] m[3];
         logic [127:0] len_sq, root, t, q;
         rsp_type   res;
         ax  = x_mem[r.index_a];
         ay  = y_mem[r.index_a];
         az  = z_mem[r.index_a];
         e1x = longint'(x_mem[r.index_b]) - ax;
         e1y = longint'(y_mem[r.index_b]) - ay;
         e1z = longint'(z_mem[r.index_b]) - az;
         e2x = longint'(x_mem[r.index_c]) - ax;
         e2y = longint'(y_mem[r.index_c]) - ay;
         e2z = longint'(z_mem[r.index_c]) - az;
         n[0] = e1y * e2z - e1z * e2y;
         n[1] = e1z * e2x - e1x * e2z;
         n[2] = e1x * e2y - e1y * e2x;
         for (int i = 0; i < 3; i++)
            m[i] = (n[i] < 0) ? 128'(-n[i]) : 128'(n[i]);
         len_sq = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
         res = '0;
         if (len_sq == 0) begin
            res.zero_length = 1'b1;
            return res;
         end
         // floor square root, one bit at a time from the top
         root = 0;
         for (int b = 63; b >= 0; b--) begin
            t = root | (128'd1 << b);
            if (t * t <= len_sq)
               root = t;
         end
         for (int i = 0; i < 3; i++) begin
            q = (m[i] * 128'd32767) / root;
            if (n[i] < 0)
               q = -q;
            case (i)
               0: res.normal_x = q[15:0];
               1: res.normal_y = q[15:0];
               default: res.normal_z = q[15:0];
            endcase
         end
         return res;
      endfunction

      function void note_transfer(req_type r);
         if (r.command == CMD_WRITE) begin
            x_mem[r.index_a] = r.pos_x;
            y_mem[r.index_a] = r.pos_y;
            z_mem[r.index_a] = r.pos_z;
         end else begin
            expected_normals.push_back(face_normal(r));
         end
      endfunction

      task check_transfer(rsp_type got);
         rsp_type exp_n;
         if (expected_normals.size() == 0) begin
            report($sformatf("unexpected response %h", got));
            return;
         end
         exp_n = expected_normals.pop_front();
         if (got.normal_x !== exp_n.normal_x)
            report($sformatf("normal_x %0d, want %0d", got.normal_x, exp_n.normal_x));
         if (got.normal_y !== exp_n.normal_y)
            report($sformatf("normal_y %0d, want %0d", got.normal_y, exp_n.normal_y));
         if (got.normal_z !== exp_n.normal_z)
            report($sformatf("normal_z %0d, want %0d", got.normal_z, exp_n.normal_z));
         if (got.zero_length !== exp_n.zero_length)
            report($sformatf("zero_length %0b, want %0b",
                             got.zero_length, exp_n.zero_length));
      endtask

      function int pending();
         return expected_normals.size();
      endfunction
   endclass

   localparam int PIPE_LATENCY = 2 * COORD_BITS + 27;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int COORD_MAX    = (1 << (COORD_BITS - 1)) - 1;
   localparam int COORD_MIN    = -(1 << (COORD_BITS - 1));

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   normal_scoreboard normals = new();
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_left      = 0;
   int cycles         = 0;
   int written[$];      // indices that hold a defined position

   triangle_face_normal dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Receiver: a long hold-off wins over the random stall mix.
   initial begin
      rsp_stall = 1'b1;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left = hold_left - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_stall_pct);
         end
      end
   end

   // Check each response transfer against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         normals.check_transfer(rsp_data);
   end

   // Watchdog: stop a hung run.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("simulation failed");
         $finish;
      end
   end

   // Offer one item, idle first at the current rate, and hold it until the
   // transfer happens.
   task send(req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do
         @(posedge clock);
      while (req_stall);
      normals.note_transfer(r);
   endtask

   task write_vertex(int idx, int px, int py, int pz);
      req_type r;
      r.command = CMD_WRITE;
      r.index_a = INDEX_BITS'(idx);
      r.index_b = INDEX_BITS'($urandom);
      r.index_c = INDEX_BITS'($urandom);
      r.pos_x   = POS_BITS'(px);
      r.pos_y   = POS_BITS'(py);
      r.pos_z   = POS_BITS'(pz);
      send(r);
      written.push_back(idx);
   endtask

   task triangle(int ia, int ib, int ic);
      req_type r;
      r.command = CMD_TRIANGLE;
      r.index_a = INDEX_BITS'(ia);
      r.index_b = INDEX_BITS'(ib);
      r.index_c = INDEX_BITS'(ic);
      // position fields are ignored on a triangle: fill them with noise
      r.pos_x   = POS_BITS'($urandom);
      r.pos_y   = POS_BITS'($urandom);
      r.pos_z   = POS_BITS'($urandom);
      send(r);
   endtask

   function int rand_coord();
      case ($urandom_range(3))
         0: return $urandom_range(255) - 128;
         1: return $urandom_range(65535) - 32768;
         2: return $urandom_range(1) ? COORD_MAX - $urandom_range(3)
                                     : COORD_MIN + $urandom_range(3);
         default: return int'({{8{1'b0}}, 24'($urandom)} << 8) >>> 8;
      endcase
   endfunction

   task random_item();
      int idx;
      if (written.size() < 3 || $urandom_range(99) < 40) begin
         idx = ($urandom_range(99) < 70) ? $urandom_range(31) : $urandom_range(4095);
         write_vertex(idx, rand_coord(), rand_coord(), rand_coord());
      end else if ($urandom_range(99) < 10) begin
         // repeated vertex: degenerate triangle
         idx = written[$urandom_range(written.size() - 1)];
         triangle(idx, idx, written[$urandom_range(written.size() - 1)]);
      end else begin
         triangle(written[$urandom_range(written.size() - 1)],
                  written[$urandom_range(written.size() - 1)],
                  written[$urandom_range(written.size() - 1)]);
      end
   endtask

   task drain();
      req_valid <= 1'b0;
      while (normals.pending() != 0)
         @(posedge clock);
   endtask

   initial begin
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: extreme corners, a unit-ish triangle, zero cross products,
      // reversed winding, collinear points and the top of the index range.
      write_vertex(0, COORD_MIN, COORD_MIN, COORD_MIN);
      write_vertex(1, COORD_MAX, COORD_MIN, COORD_MIN);
      write_vertex(2, COORD_MIN, COORD_MAX, COORD_MIN);
      write_vertex(3, COORD_MIN, COORD_MIN, COORD_MAX);
      write_vertex(4, 0, 0, 0);
      write_vertex(5, 4096, 0, 0);
      write_vertex(6, 0, 4096, 0);
      write_vertex(7, 8192, 0, 0);
      write_vertex(4095, COORD_MAX, COORD_MAX, COORD_MAX);
      write_vertex(4094, COORD_MAX, COORD_MIN, COORD_MAX);
      triangle(0, 1, 2);
      triangle(0, 2, 1);
      triangle(0, 1, 3);
      triangle(1, 2, 3);
      triangle(4095, 0, 4094);
      triangle(4094, 1, 2);
      triangle(4, 5, 6);
      triangle(6, 5, 4);
      triangle(4, 5, 7);      // collinear
      triangle(3, 3, 3);      // one vertex three times
      triangle(4, 4, 5);
      triangle(4095, 4094, 3);
      drain();

      // Phase 1: no idling, with a long receiver hold-off that backs the
      // pipeline up into the request side.
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_left      = 300;
      repeat (225) random_item();
      drain();

      // Phase 2: sparse sender.
      send_idle_pct  = 76;
      recv_stall_pct = 0;
      repeat (225) random_item();
      drain();

      // Phase 3: heavy receiver stalls.
      send_idle_pct  = 0;
      recv_stall_pct = 76;
      repeat (225) random_item();
      drain();

      // Phase 4: light idling on both sides.
      send_idle_pct  = 12;
      recv_stall_pct = 12;
      repeat (225) random_item();
      drain();

      recv_stall_pct = 0;
      repeat (PIPE_LATENCY + 20) @(posedge clock);
      if (normals.mismatches == 0 && normals.pending() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end
endmodule

// ===== files.f =====
hw/rtl/tfn_pkg.sv
hw/rtl/tfn_vertex_store.sv
hw/rtl/tfn_cross.sv
hw/rtl/tfn_length.sv
hw/rtl/tfn_sqrt.sv
hw/rtl/tfn_divide.sv
hw/rtl/triangle_face_normal.sv
tb/tb.sv
